[sv/skf_pkg.sv]
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the knock filter with per-source rate limit.
// ----------------------------------------------------------------------------
package skf_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int WATCH_SLOTS   = 4;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [63:0] DEFAULT_WINDOW = 64'd60000000000;
	localparam logic [7:0]  DEFAULT_LIMIT  = 8'd5;
	localparam logic [7:0]  COUNT_MAX      = 8'd255;

	typedef enum logic [2:0] {
		REG_FILTER_ENABLED = 3'd0,
		REG_SEQ_KEY        = 3'd1,
		REG_WATCH_PORTS    = 3'd2,
		REG_WINDOW_NS      = 3'd3,
		REG_KNOCK_LIMIT    = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		VERDICT_NO_MATCH = 2'd0,
		VERDICT_LIMITED  = 2'd1,
		VERDICT_ACCEPT   = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_RESP
	} back_state_t;

	typedef struct packed {
		logic        filter_enabled;
		logic [15:0] seq_key;
		logic [63:0] watch_ports;
		logic [63:0] window_ns;
		logic [7:0]  knock_limit;
	} cfg_t;

	// classified packet handed from front to back
	typedef struct packed {
		logic        matched;
		logic [31:0] source_addr;
		logic [63:0] now_ns;
	} work_t;

	typedef struct packed {
		logic [31:0] source;
		logic [63:0] start;
		logic [7:0]  count;
	} entry_t;

endpackage

[sv/skf_if.sv]
// ----------------------------------------------------------------------------
// skf_req_if / skf_rsp_if
// Valid/ready channels for packet headers and verdicts.
// ----------------------------------------------------------------------------
interface skf_req_if;
	logic        valid;
	logic        ready;
	logic        headers_complete;
	logic [15:0] ethertype;
	logic [7:0]  ip_protocol;
	logic        syn_flag;
	logic        ack_flag;
	logic [15:0] dest_port;
	logic [31:0] seq_number;
	logic [31:0] source_addr;
	logic [63:0] now_ns;

	modport source (output valid, headers_complete, ethertype, ip_protocol, syn_flag,
		ack_flag, dest_port, seq_number, source_addr, now_ns, input ready);
	modport sink (input valid, headers_complete, ethertype, ip_protocol, syn_flag,
		ack_flag, dest_port, seq_number, source_addr, now_ns, output ready);
endinterface

interface skf_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic       not_recorded;

	modport source (output valid, verdict, not_recorded, input ready);
	modport sink (input valid, verdict, not_recorded, output ready);
endinterface

[sv/syn_knock_filter_rate_limit.sv]
// ----------------------------------------------------------------------------
// syn_knock_filter_rate_limit
// Port knock detector with a per-source rate limiter.
// ----------------------------------------------------------------------------
// usage:
//   req carries one parsed header per transfer, rsp returns one verdict per
//   header in arrival order. cfg_we/cfg_index/cfg_data write the five
//   registers; write them only while no header is in flight.
//   the front classifies a header in the cycle it is taken and parks it in
//   an output register, a two-entry queue feeds the limiter.
//   a header that does not match, or matches while the table is empty, goes
//   from the queue straight to the response state. any other matching header
//   scans the filled part of the source table, one entry at a time through
//   the single table read port, up to the entry of its source (all filled
//   entries when the source is new).
//   the limiter handles one header at a time, from taking it to its verdict.
//   reset: registers return to defaults, the table is emptied at once by
//   clearing its fill count, no clearing pass.
//   a stalled rsp holds its verdict; the queue keeps taking headers until it
//   and the front register are full, then req.ready drops.
// ----------------------------------------------------------------------------
module syn_knock_filter_rate_limit
	import skf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	skf_req_if.sink     req,
	skf_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t  cfg_q;
	logic  f_valid, f_ready, b_valid, b_ready;
	work_t f_work, b_work;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{filter_enabled: 1'b0, seq_key: 16'd0, watch_ports: 64'd0,
				window_ns: DEFAULT_WINDOW, knock_limit: DEFAULT_LIMIT};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_ENABLED: cfg_q.filter_enabled <= cfg_data[0];
				REG_SEQ_KEY:        cfg_q.seq_key        <= cfg_data[15:0];
				REG_WATCH_PORTS:    cfg_q.watch_ports    <= cfg_data;
				REG_WINDOW_NS:      cfg_q.window_ns      <= cfg_data;
				REG_KNOCK_LIMIT:    cfg_q.knock_limit    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	skf_front u_front (
		.clk, .arst_n, .req, .cfg(cfg_q),
		.work_valid(f_valid), .work_ready(f_ready), .work(f_work)
	);

	skf_fifo u_fifo (
		.clk, .arst_n,
		.push_valid(f_valid), .push_ready(f_ready), .push_data(f_work),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_work)
	);

	skf_back u_back (
		.clk, .arst_n,
		.work_valid(b_valid), .work_ready(b_ready), .work(b_work),
		.cfg(cfg_q), .rsp
	);

endmodule

[sv/skf_front.sv]
// ----------------------------------------------------------------------------
// skf_front
// Classifies each header and holds the classified item in an output register.
// ----------------------------------------------------------------------------
module skf_front
	import skf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	skf_req_if.sink     req,
	input  cfg_t        cfg,
	output logic        work_valid,
	input  logic        work_ready,
	output work_t       work
);

	logic  valid_q;
	work_t work_q;
	logic  watched;
	logic  stop;
	logic  matched;

	// search stops at the first empty slot
	always_comb begin
		logic [15:0] slot;
		watched = 1'b0;
		stop    = 1'b0;
		for (int i = 0; i < WATCH_SLOTS; i++) begin
			slot = cfg.watch_ports[16*i +: 16];
			if (!stop) begin
				if (slot == 16'd0) begin
					stop = 1'b1;
				end else if (slot == req.dest_port) begin
					watched = 1'b1;
					stop    = 1'b1;
				end
			end
		end
	end

	assign matched = req.headers_complete && (req.ethertype == ETHERTYPE_IPV4)
		&& (req.ip_protocol == PROTO_TCP) && req.syn_flag && !req.ack_flag
		&& watched && cfg.filter_enabled && (req.seq_number[31:16] == cfg.seq_key);

	assign req.ready  = !valid_q || work_ready;
	assign work_valid = valid_q;
	assign work       = work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.ready) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			work_q <= '{matched: matched, source_addr: req.source_addr, now_ns: req.now_ns};
		end
	end

endmodule

[sv/skf_fifo.sv]
// ----------------------------------------------------------------------------
// skf_fifo
// Two-entry queue between the classifier and the limiter.
// ----------------------------------------------------------------------------
module skf_fifo
	import skf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_data
);

	work_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) count_q != 2'd3;
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("fifo count out of range");

	property p_pop_needs_data;
		@(posedge clk) disable iff (!arst_n) (count_q == 2'd0) |-> !pop;
	endproperty
	a_pop_needs_data: assert property (p_pop_needs_data) else $error("pop from empty fifo");

	property p_full_blocks;
		@(posedge clk) disable iff (!arst_n) (count_q == 2'd2) |-> !push;
	endproperty
	a_full_blocks: assert property (p_full_blocks) else $error("push into full fifo");

endmodule

[sv/skf_back.sv]
// ----------------------------------------------------------------------------
// skf_back
// Per-source limiter: for a matching header scans the filled part of the
// source table and updates it; registers the verdict of every header.
// ----------------------------------------------------------------------------
module skf_back
	import skf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    work_valid,
	output logic    work_ready,
	input  work_t   work,
	input  cfg_t    cfg,
	skf_rsp_if.source rsp
);

	back_state_t      state_q, state_d;
	work_t            item_q;
	logic [IDX_W-1:0] idx_q;
	logic [FILL_W-1:0] fill_q;
	logic [1:0]       verdict_q;
	logic             nrec_q;

	entry_t           mem [TABLE_ENTRIES];
	entry_t           rd_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t           mem_wd;
	logic             fill_inc;
	logic             load_idx;
	logic             step_idx;
	logic             set_res;
	logic [1:0]       verdict_d;
	logic             nrec_d;

	logic             hit;
	logic             last;
	logic             full;
	logic             expired;
	logic [7:0]       cnt_next;
	logic [63:0]      age;

	assign hit      = (rd_q.source == item_q.source_addr);
	assign last     = ({1'b0, idx_q} + FILL_W'(1)) == fill_q;
	assign full     = (fill_q == FILL_W'(TABLE_ENTRIES));
	assign age      = item_q.now_ns - rd_q.start;
	assign expired  = age > cfg.window_ns;
	assign cnt_next = (rd_q.count == COUNT_MAX) ? COUNT_MAX : rd_q.count + 8'd1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (work_valid) begin
					if (!work.matched || fill_q == '0) state_d = BK_RESP;
					else state_d = BK_READ;
				end
			end
			BK_READ:  state_d = BK_CHECK;
			BK_CHECK: state_d = (hit || last) ? BK_RESP : BK_READ;
			BK_RESP:  if (rsp.ready) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		work_ready = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = '0;
		mem_wd     = '{source: item_q.source_addr, start: item_q.now_ns, count: 8'd1};
		fill_inc   = 1'b0;
		load_idx   = 1'b0;
		step_idx   = 1'b0;
		set_res    = 1'b0;
		verdict_d  = VERDICT_NO_MATCH;
		nrec_d     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				work_ready = 1'b1;
				load_idx   = 1'b1;
				if (work_valid) begin
					set_res = 1'b1;
					if (work.matched && fill_q == '0) begin
						mem_we    = 1'b1;
						mem_wd    = '{source: work.source_addr, start: work.now_ns, count: 8'd1};
						fill_inc  = 1'b1;
						verdict_d = VERDICT_ACCEPT;
					end
				end
			end
			BK_CHECK: begin
				if (hit) begin
					set_res = 1'b1;
					mem_we  = 1'b1;
					mem_wa  = idx_q;
					if (expired) begin
						verdict_d = VERDICT_ACCEPT;
					end else begin
						mem_wd    = '{source: rd_q.source, start: rd_q.start, count: cnt_next};
						verdict_d = (cnt_next > cfg.knock_limit) ? VERDICT_LIMITED
							: VERDICT_ACCEPT;
					end
				end else if (last) begin
					set_res   = 1'b1;
					verdict_d = VERDICT_ACCEPT;
					if (full) begin
						nrec_d = 1'b1;
					end else begin
						mem_we   = 1'b1;
						mem_wa   = fill_q[IDX_W-1:0];
						fill_inc = 1'b1;
					end
				end else begin
					step_idx = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (fill_inc) fill_q <= fill_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (work_ready && work_valid) item_q <= work;
		if (load_idx) idx_q <= '0;
		else if (step_idx) idx_q <= idx_q + IDX_W'(1);
		if (set_res) begin
			verdict_q <= verdict_d;
			nrec_q    <= nrec_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q];
	end

	assign rsp.valid        = (state_q == BK_RESP);
	assign rsp.verdict      = verdict_q;
	assign rsp.not_recorded = nrec_q;

	property p_fill_bound;
		@(posedge clk) disable iff (!arst_n) fill_q <= FILL_W'(TABLE_ENTRIES);
	endproperty
	a_fill_bound: assert property (p_fill_bound) else $error("fill count beyond table");

	property p_nrec_accept;
		@(posedge clk) disable iff (!arst_n)
			(rsp.valid && rsp.not_recorded) |-> (rsp.verdict == VERDICT_ACCEPT);
	endproperty
	a_nrec_accept: assert property (p_nrec_accept) else $error("not_recorded without accept");

	property p_fill_only_on_match;
		@(posedge clk) disable iff (!arst_n)
			(fill_q != $past(fill_q)) |-> $past(mem_we);
	endproperty
	a_fill_only_on_match: assert property (p_fill_only_on_match)
		else $error("fill count moved without table write");

endmodule

[dv/syn_knock_filter_rate_limit_tb.sv]
// ----------------------------------------------------------------------------
// syn_knock_filter_rate_limit_tb
// Self-checking bench for the knock filter. A directed table covers header
// rejects, watch list termination, window edges and address extremes. Random
// phases then sweep the registers, idle and stall patterns and a long receiver
// hold-off. The last phase fills the source table and goes past it. Every
// verdict is compared with a pinned value or an in-bench scoreboard of the limiter.
// ----------------------------------------------------------------------------
module syn_knock_filter_rate_limit_tb
	import skf_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        headers_complete;
		logic [15:0] ethertype;
		logic [7:0]  ip_protocol;
		logic        syn_flag;
		logic        ack_flag;
		logic [15:0] dest_port;
		logic [31:0] seq_number;
		logic [31:0] source_addr;
		logic [63:0] now_ns;
	} hdr_t;

	typedef struct {
		bit       has;
		verdict_t verdict;
		logic     not_recorded;
	} pin_t;

	typedef struct {
		verdict_t verdict;
		logic     not_recorded;
	} verdict_rec_t;

	typedef struct {
		bit       cfg_before;
		hdr_t     hdr;
		bit       has;
		verdict_t verdict;
		logic     not_recorded;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	skf_req_if req ();
	skf_rsp_if rsp ();

	syn_knock_filter_rate_limit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register shadow
	logic        sh_en;
	logic [15:0] sh_magic;
	logic [63:0] sh_watch;
	logic [63:0] sh_window;
	logic [7:0]  sh_limit;

	// source table shadow; entries are never freed, so fill count marks the free slot
	logic [31:0] tbl_src   [TABLE_ENTRIES];
	logic [63:0] tbl_start [TABLE_ENTRIES];
	logic [7:0]  tbl_cnt   [TABLE_ENTRIES];
	int          tbl_fill;

	verdict_rec_t pending_verdicts [$];
	pin_t         pins [$];

	int errors;
	int n_sent, n_checked, n_accept, n_limited, n_unrec;
	int idle_pct, stall_pct;
	logic hold_on;
	event kick_hold;
	logic [63:0] wall_ns;
	logic [31:0] pool_src [16];

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#200_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bit port_listed(logic [15:0] port);
		logic [15:0] slot;
		for (int i = 0; i < WATCH_SLOTS; i++) begin
			slot = sh_watch[16*i +: 16];
			if (slot == 16'd0) return 1'b0;
			if (slot == port) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void judge_knock(input hdr_t h, output verdict_t v, output logic nr);
		int hit;
		hit = -1;
		v = VERDICT_NO_MATCH;
		nr = 1'b0;
		if (!h.headers_complete || h.ethertype != ETHERTYPE_IPV4 || h.ip_protocol != PROTO_TCP)
			return;
		if (!h.syn_flag || h.ack_flag || !port_listed(h.dest_port) || !sh_en)
			return;
		if (h.seq_number[31:16] != sh_magic)
			return;
		for (int i = 0; i < tbl_fill; i++) begin
			if (tbl_src[i] == h.source_addr) begin
				hit = i;
				break;
			end
		end
		v = VERDICT_ACCEPT;
		if (hit < 0) begin
			if (tbl_fill < TABLE_ENTRIES) begin
				tbl_src[tbl_fill] = h.source_addr;
				tbl_start[tbl_fill] = h.now_ns;
				tbl_cnt[tbl_fill] = 8'd1;
				tbl_fill++;
			end else begin
				nr = 1'b1;
			end
		end else if (h.now_ns - tbl_start[hit] > sh_window) begin
			tbl_start[hit] = h.now_ns;
			tbl_cnt[hit] = 8'd1;
		end else begin
			if (tbl_cnt[hit] != COUNT_MAX) tbl_cnt[hit] = tbl_cnt[hit] + 8'd1;
			if (tbl_cnt[hit] > sh_limit) v = VERDICT_LIMITED;
		end
	endfunction

	// monitor: predicts on each header transfer, checks each verdict transfer
	always @(posedge clk) begin
		hdr_t h;
		pin_t pin;
		verdict_rec_t e;
		if (arst_n && req.valid && req.ready) begin
			h = '{req.headers_complete, req.ethertype, req.ip_protocol, req.syn_flag,
				req.ack_flag, req.dest_port, req.seq_number, req.source_addr, req.now_ns};
			pin = pins.pop_front();
			judge_knock(h, e.verdict, e.not_recorded);
			if (pin.has) begin
				e.verdict = pin.verdict;
				e.not_recorded = pin.not_recorded;
			end
			pending_verdicts.push_back(e);
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: verdict with nothing expected, actual %0d/%0d", $time,
					rsp.verdict, rsp.not_recorded);
				errors++;
			end else begin
				e = pending_verdicts.pop_front();
				n_checked++;
				if (e.verdict == VERDICT_LIMITED) n_limited++;
				if (e.verdict == VERDICT_ACCEPT) n_accept++;
				if (e.not_recorded) n_unrec++;
				if (rsp.verdict !== e.verdict) begin
					$display("%0t: verdict mismatch, expected %0d actual %0d", $time,
						e.verdict, rsp.verdict);
					errors++;
				end
				if (rsp.not_recorded !== e.not_recorded) begin
					$display("%0t: not_recorded mismatch, expected %0d actual %0d", $time,
						e.not_recorded, rsp.not_recorded);
					errors++;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_on) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// long receiver hold-off, counted here
	initial begin
		hold_on = 1'b0;
		forever begin
			@(kick_hold);
			@(posedge clk);
			hold_on <= 1'b1;
			repeat (400) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	task automatic offer(input hdr_t h, input bit has, input verdict_t v, input logic nr);
		pin_t pin;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req.headers_complete <= h.headers_complete;
		req.ethertype        <= h.ethertype;
		req.ip_protocol      <= h.ip_protocol;
		req.syn_flag         <= h.syn_flag;
		req.ack_flag         <= h.ack_flag;
		req.dest_port        <= h.dest_port;
		req.seq_number       <= h.seq_number;
		req.source_addr      <= h.source_addr;
		req.now_ns           <= h.now_ns;
		req.valid            <= 1'b1;
		pin.has = has;
		pin.verdict = v;
		pin.not_recorded = nr;
		pins.push_back(pin);
		do @(posedge clk); while (!req.ready);
		n_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_verdicts.size() != 0 || pins.size() != 0) @(posedge clk);
	endtask

	task automatic set_regs(input logic en, input logic [15:0] magic, input logic [63:0] watch,
			input logic [63:0] win, input logic [7:0] lim);
		logic [63:0] vals [5];
		reg_index_t idx [5];
		vals = '{{63'd0, en}, {48'd0, magic}, watch, win, {56'd0, lim}};
		idx = '{REG_FILTER_ENABLED, REG_SEQ_KEY, REG_WATCH_PORTS, REG_WINDOW_NS,
			REG_KNOCK_LIMIT};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		sh_en = en;
		sh_magic = magic;
		sh_watch = watch;
		sh_window = win;
		sh_limit = lim;
	endtask

	function automatic logic [63:0] rand_watch();
		logic [63:0] w;
		w[15:0] = 16'($urandom_range(1, 65535));
		for (int i = 1; i < 4; i++)
			w[16*i +: 16] = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
		return w;
	endfunction

	function automatic logic [15:0] pick_port();
		int nv;
		nv = 0;
		while (nv < WATCH_SLOTS && sh_watch[16*nv +: 16] != 16'd0) nv++;
		if (nv == 0) return 16'($urandom_range(1, 65535));
		return sh_watch[16*$urandom_range(nv - 1) +: 16];
	endfunction

	function automatic void step_wall();
		case ($urandom_range(5))
			0: ;
			1: wall_ns += 64'($urandom_range(1000));
			2: wall_ns += sh_window;
			3: wall_ns += sh_window + 64'd1;
			4: wall_ns += {$urandom, $urandom};
			default: wall_ns += sh_window >> 1;
		endcase
	endfunction

	function automatic hdr_t make_hdr(input int pool_n, input bit clean);
		hdr_t h;
		logic [191:0] noise;
		step_wall();
		h.headers_complete = 1'b1;
		h.ethertype = ETHERTYPE_IPV4;
		h.ip_protocol = PROTO_TCP;
		h.syn_flag = 1'b1;
		h.ack_flag = 1'b0;
		h.dest_port = pick_port();
		h.seq_number = {sh_magic, 16'($urandom)};
		h.source_addr = pool_src[$urandom_range(pool_n - 1)];
		h.now_ns = wall_ns;
		if (!clean && $urandom_range(99) < 22) begin
			case ($urandom_range(6))
				0: h.headers_complete = 1'b0;
				1: h.ethertype = 16'($urandom);
				2: h.ip_protocol = 8'($urandom);
				3: {h.syn_flag, h.ack_flag} = 2'($urandom);
				4: h.dest_port = 16'($urandom);
				5: h.seq_number = $urandom;
				default: begin
					noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
					h = noise[$bits(hdr_t)-1:0];
				end
			endcase
		end
		return h;
	endfunction

	task automatic run_phase(input int n, input int pool_n);
		for (int i = 0; i < n; i++)
			offer(make_hdr(pool_n, 1'b0), 1'b0, VERDICT_NO_MATCH, 1'b0);
	endtask

	function automatic row_t mk(input bit cfg, input logic cpl, input logic [15:0] et,
			input logic [7:0] pr, input logic syn, input logic ack, input logic [15:0] port,
			input logic [31:0] seq, input logic [31:0] src, input logic [63:0] now,
			input bit has, input verdict_t v, input logic nr);
		row_t r;
		r.cfg_before = cfg;
		r.hdr = '{cpl, et, pr, syn, ack, port, seq, src, now};
		r.has = has;
		r.verdict = v;
		r.not_recorded = nr;
		return r;
	endfunction

	localparam logic [31:0] SRC_A = 32'hC0A8_0001;
	localparam logic [63:0] ALL1  = 64'hFFFF_FFFF_FFFF_FFFF;

	initial begin
		row_t rows [$];
		hdr_t h;
		int extra;
		req.valid = 1'b0;
		req.headers_complete = 1'b0;
		req.ethertype = '0;
		req.ip_protocol = '0;
		req.syn_flag = 1'b0;
		req.ack_flag = 1'b0;
		req.dest_port = '0;
		req.seq_number = '0;
		req.source_addr = '0;
		req.now_ns = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_accept = 0;
		n_limited = 0;
		n_unrec = 0;
		idle_pct = 0;
		stall_pct = 0;
		tbl_fill = 0;
		wall_ns = 64'd10_000;
		sh_en = 1'b0;
		sh_magic = '0;
		sh_watch = '0;
		sh_window = DEFAULT_WINDOW;
		sh_limit = DEFAULT_LIMIT;
		pool_src[0] = 32'h0000_0000;
		pool_src[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 16; i++) pool_src[i] = {16'hC0A9, 16'($urandom)};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults first, then a fixed setup for the rest
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_0000, SRC_A, 64'd100,
			1, VERDICT_NO_MATCH, 0));
		rows.push_back(mk(1, 0, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_0000, SRC_A, 64'd200,
			1, VERDICT_NO_MATCH, 0));
		rows.push_back(mk(0, 1, 16'h86DD, 8'd6, 1, 0, 16'd22, 32'hABCD_0000, SRC_A, 64'd200,
			1, VERDICT_NO_MATCH, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd17, 1, 0, 16'd22, 32'hABCD_0000, SRC_A, 64'd200,
			1, VERDICT_NO_MATCH, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 0, 0, 16'd22, 32'hABCD_0000, SRC_A, 64'd200,
			1, VERDICT_NO_MATCH, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 1, 16'd22, 32'hABCD_0000, SRC_A, 64'd200,
			1, VERDICT_NO_MATCH, 0));
		// port listed after the terminating zero slot
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd7777, 32'hABCD_0000, SRC_A, 64'd200,
			1, VERDICT_NO_MATCH, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd0, 32'hABCD_0000, SRC_A, 64'd200,
			1, VERDICT_NO_MATCH, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hFFFF_FFFF, SRC_A, 64'd200,
			1, VERDICT_NO_MATCH, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_0000, SRC_A, 64'd5000,
			1, VERDICT_ACCEPT, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'hFFFF, 32'hABCD_FFFF, SRC_A, 64'd5500,
			1, VERDICT_ACCEPT, 0));
		// elapsed equal to the window is still inside it
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_1234, SRC_A, 64'd6000,
			1, VERDICT_LIMITED, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_0001, SRC_A, 64'd6001,
			1, VERDICT_ACCEPT, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_0000, 32'd0, 64'd6001,
			1, VERDICT_ACCEPT, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_0000, 32'hFFFF_FFFF,
			ALL1, 1, VERDICT_ACCEPT, 0));
		// time wraps past zero, elapsed stays small
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_0000, 32'hFFFF_FFFF,
			64'd5, 1, VERDICT_ACCEPT, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_0000, 32'hFFFF_FFFF,
			64'd7, 1, VERDICT_LIMITED, 0));
		rows.push_back(mk(0, 1, 16'h0800, 8'd6, 1, 0, 16'd22, 32'hABCD_0000, SRC_A, 64'd6100,
			0, VERDICT_NO_MATCH, 0));
		foreach (rows[i]) begin
			if (rows[i].cfg_before) begin
				drain();
				set_regs(1'b1, 16'hABCD, {16'd7777, 16'd0, 16'hFFFF, 16'd22}, 64'd1000, 8'd2);
			end
			offer(rows[i].hdr, rows[i].has, rows[i].verdict, rows[i].not_recorded);
		end

		drain();
		set_regs(1'b1, 16'($urandom), rand_watch(), 64'($urandom), 8'($urandom_range(1, 8)));
		run_phase(200, 8);

		drain();
		idle_pct = 49;
		set_regs(1'b1, 16'hFFFF, rand_watch(), 64'd0, 8'd0);
		run_phase(150, 12);

		drain();
		idle_pct = 0;
		stall_pct = 49;
		set_regs(1'b1, 16'h0000, rand_watch(), ALL1, 8'd255);
		run_phase(150, 16);

		drain();
		idle_pct = 6;
		stall_pct = 6;
		set_regs(1'b1, 16'($urandom), rand_watch(), 64'($urandom_range(1, 5000)),
			8'($urandom_range(1, 6)));
		run_phase(150, 16);

		// one source hammered in an endless window drives the count into saturation
		drain();
		idle_pct = 0;
		stall_pct = 0;
		set_regs(1'b1, 16'h5A5A, rand_watch(), ALL1, 8'd200);
		for (int i = 0; i < 280; i++) begin
			h = make_hdr(1, 1'b1);
			h.source_addr = 32'hC0A8_0055;
			offer(h, 1'b0, VERDICT_NO_MATCH, 1'b0);
		end

		drain();
		set_regs(1'b0, 16'($urandom), rand_watch(), 64'($urandom), 8'($urandom));
		run_phase(40, 16);

		// receiver holds off while headers keep coming, then the sender waits it out
		drain();
		set_regs(1'b1, 16'h0F0F, rand_watch(), 64'd100_000, 8'd3);
		->kick_hold;
		run_phase(30, 4);
		drain();
		repeat (50) @(posedge clk);

		// fill the source table and go past it
		set_regs(1'b1, 16'h1234, rand_watch(), ALL1, 8'd3);
		idle_pct = 6;
		stall_pct = 6;
		extra = 0;
		for (int n = 0; extra < 8; n++) begin
			h = make_hdr(4, 1'b1);
			h.source_addr = 32'h0A00_0000 + n;
			offer(h, 1'b0, VERDICT_NO_MATCH, 1'b0);
			if (tbl_fill == TABLE_ENTRIES) extra++;
		end
		run_phase(12, 4);

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d headers, %0d verdicts: %0d accepted, %0d limited, %0d unrecorded",
			n_sent, n_checked, n_accept, n_limited, n_unrec);
		$display("table ended with %0d of %0d sources", tbl_fill, TABLE_ENTRIES);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/skf_pkg.sv
sv/skf_if.sv
sv/skf_front.sv
sv/skf_fifo.sv
sv/skf_back.sv
sv/syn_knock_filter_rate_limit.sv
dv/syn_knock_filter_rate_limit_tb.sv
